>>> rtl/core/sacm_pkg.sv
// Shared types, constants and a helper function for the cache tag model.
// No dependencies; every other file in rtl/core imports this package.
package sacm_pkg;

  localparam int DEF_MAX_SETS = 64;
  localparam int DEF_MAX_WAYS = 8;
  localparam int SET_FIELD_W  = 7;  // set_count_log2 is 3 bits wide
  localparam int CFG_DATA_W   = 4;

  typedef enum logic [2:0] {
    REG_REPLACE_POLICY    = 3'd0,
    REG_WRITE_MISS_POLICY = 3'd1,
    REG_BLOCK_SIZE_LOG2   = 3'd2,
    REG_SET_COUNT_LOG2    = 3'd3,
    REG_WAY_COUNT_LOG2    = 3'd4
  } reg_index_t;

  localparam logic [1:0] POL_RANDOM = 2'd0;
  localparam logic [1:0] POL_RROBIN = 2'd1;
  localparam logic [1:0] POL_LRU    = 2'd2;

  typedef struct packed {
    logic [1:0] replace_policy;
    logic       write_miss_policy;
    logic [3:0] block_size_log2;
    logic [2:0] set_count_log2;
    logic [1:0] way_count_log2;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] address;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic        allocated;
    logic        evicted;
    logic [2:0]  way_used;
    logic [31:0] access_total;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] evict_total;
  } out_t;

  typedef struct packed {
    logic                   mode;
    logic [SET_FIELD_W-1:0] set;
    logic [31:0]            tag;
  } q_entry_t;

  // Largest l <= lg whose power of two does not exceed limit.
  function automatic logic [2:0] fit_log2(input logic [2:0] lg, input int limit);
    logic [2:0] res;
    res = 3'd0;
    for (int l = 0; l < 8; l++) begin
      if ((3'(l) <= lg) && ((1 << l) <= limit)) res = 3'(l);
    end
    return res;
  endfunction

endpackage

>>> rtl/core/sacm_front.sv
// Front end: splits each access address into set index and tag.
// Depends on sacm_pkg.
module sacm_front import sacm_pkg::*; #(
  parameter int MAX_SETS = DEF_MAX_SETS
) (
  input  cfg_t     cfg,
  input  in_t      item,
  output q_entry_t entry
);

  logic [2:0]  sbits;
  logic [31:0] shifted;
  logic [4:0]  tag_lsb;

  always_comb begin
    sbits      = fit_log2(cfg.set_count_log2, MAX_SETS);
    shifted    = item.address >> cfg.block_size_log2;
    tag_lsb    = 5'(cfg.block_size_log2) + 5'(sbits);
    entry.mode = item.mode;
    entry.set  = shifted[SET_FIELD_W-1:0] & SET_FIELD_W'((8'd1 << sbits) - 8'd1);
    entry.tag  = item.address >> tag_lsb;
  end

endmodule

>>> rtl/core/sacm_queue.sv
// Two-entry queue between the front end and the lookup engine.
// Depends on sacm_pkg.
module sacm_queue import sacm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output q_entry_t head
);

  q_entry_t   slots [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_data;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> rtl/core/sacm_back.sv
// Lookup engine: reads a set row, resolves hit or victim, writes the row back.
// Holds the set memories, the LFSR and the statistics. Depends on sacm_pkg.
module sacm_back import sacm_pkg::*; #(
  parameter int MAX_SETS = DEF_MAX_SETS,
  parameter int MAX_WAYS = DEF_MAX_WAYS
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     q_not_empty,
  input  q_entry_t q_head,
  output logic     q_pop,
  output logic     clearing,
  output logic     out_valid,
  input  logic     out_ready,
  output out_t     out_data
);

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int LV    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
  localparam int P     = 1 << LV;

  typedef struct packed {
    logic [MAX_WAYS-1:0] valid;
    logic [31:0]         cnt;
    logic [2:0]          rr;
  } ctl_row_t;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK} state_t;

  state_t   state;
  ctl_row_t ctl_mem [MAX_SETS];
  logic [MAX_WAYS-1:0][31:0] tag_mem   [MAX_SETS];
  logic [MAX_WAYS-1:0][31:0] stamp_mem [MAX_SETS];

  ctl_row_t                  r_ctl, w_ctl;
  logic [MAX_WAYS-1:0][31:0] r_tag, r_stamp, w_tag, w_stamp;
  q_entry_t                  cur;
  logic [SET_W-1:0]          clr_cnt;
  logic [15:0]               lfsr;
  logic [31:0]               st_acc, st_hit, st_miss, st_evict;

  logic [SET_W+SET_FIELD_W-1:0] head_wide, cur_wide;
  logic [SET_W-1:0]             rd_addr, cur_set;

  assign head_wide = {{SET_W{1'b0}}, q_head.set};
  assign cur_wide  = {{SET_W{1'b0}}, cur.set};
  assign rd_addr   = head_wide[SET_W-1:0];
  assign cur_set   = cur_wide[SET_W-1:0];
  assign clearing  = (state == ST_CLEAR);
  assign q_pop     = (state == ST_IDLE) && q_not_empty && (!out_valid || out_ready);

  // Lookup logic on the registered row.
  logic [3:0]  ways;
  logic [2:0]  way_mask, hway, inv_way, victim, way;
  logic        hit, inv_found, do_alloc, full_pick;
  logic [15:0] lfsr_nxt;
  logic        nd_c [P];
  logic [31:0] nd_s [P];
  logic [2:0]  nd_i [P];
  logic        ta, tb;

  always_comb begin
    ways     = 4'd1 << fit_log2({1'b0, cfg.way_count_log2}, MAX_WAYS);
    way_mask = 3'(ways - 4'd1);
    hit = 1'b0; hway = 3'd0; inv_found = 1'b0; inv_way = 3'd0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (4'(w) < ways) begin
        if (r_ctl.valid[w] && r_tag[w] == cur.tag) begin
          hit = 1'b1; hway = 3'(w);
        end
        if (!r_ctl.valid[w]) begin
          inv_found = 1'b1; inv_way = 3'(w);
        end
      end
    end
    // Oldest stamp by a tree; the lower way wins a tie.
    for (int i = 0; i < P; i++) begin
      nd_c[i] = (i < MAX_WAYS) && (4'(i) < ways);
      nd_s[i] = (i < MAX_WAYS) ? r_stamp[i % MAX_WAYS] : 32'd0;
      nd_i[i] = 3'(i);
    end
    for (int l = 0; l < LV; l++) begin
      for (int i = 0; i < (P >> (l + 1)); i++) begin
        ta = nd_c[2*i];
        tb = nd_c[2*i+1];
        if (ta && (!tb || nd_s[2*i] <= nd_s[2*i+1])) begin
          nd_c[i] = ta; nd_s[i] = nd_s[2*i]; nd_i[i] = nd_i[2*i];
        end else begin
          nd_c[i] = tb; nd_s[i] = nd_s[2*i+1]; nd_i[i] = nd_i[2*i+1];
        end
      end
    end
    lfsr_nxt = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
    case (cfg.replace_policy)
      POL_RANDOM: victim = lfsr_nxt[2:0] & way_mask;
      POL_RROBIN: victim = r_ctl.rr & way_mask;
      POL_LRU:    victim = nd_i[0];
      default:    victim = 3'd0;
    endcase
    do_alloc  = !hit && !(cur.mode && cfg.write_miss_policy);
    full_pick = do_alloc && !inv_found;
    way       = hit ? hway : (do_alloc ? (inv_found ? inv_way : victim) : 3'd0);

    w_ctl   = r_ctl;
    w_tag   = r_tag;
    w_stamp = r_stamp;
    if (hit || do_alloc) w_ctl.cnt = r_ctl.cnt + 32'd1;
    if (full_pick && cfg.replace_policy == POL_RROBIN) w_ctl.rr = r_ctl.rr + 3'd1;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (3'(w) == way && (hit || do_alloc)) w_stamp[w] = r_ctl.cnt;
      if (3'(w) == way && do_alloc) begin
        w_ctl.valid[w] = 1'b1;
        w_tag[w]       = cur.tag;
      end
    end
  end

  // Set memories.
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) ctl_mem[clr_cnt] <= '0;
    else if (state == ST_LOOK) begin
      ctl_mem[cur_set]   <= w_ctl;
      tag_mem[cur_set]   <= w_tag;
      stamp_mem[cur_set] <= w_stamp;
    end
    if (q_pop) begin
      r_ctl   <= ctl_mem[rd_addr];
      r_tag   <= tag_mem[rd_addr];
      r_stamp <= stamp_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      lfsr      <= 16'hACE1;
      st_acc    <= '0;
      st_hit    <= '0;
      st_miss   <= '0;
      st_evict  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + SET_W'(1);
          if (clr_cnt == SET_W'(MAX_SETS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_pop) begin
            cur   <= q_head;
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (full_pick && cfg.replace_policy == POL_RANDOM) lfsr <= lfsr_nxt;
          st_acc   <= st_acc + 32'd1;
          st_hit   <= st_hit + 32'(hit);
          st_miss  <= st_miss + 32'(!hit);
          st_evict <= st_evict + 32'(full_pick);
          out_data.hit          <= hit;
          out_data.allocated    <= do_alloc;
          out_data.evicted      <= full_pick;
          out_data.way_used     <= way;
          out_data.access_total <= st_acc + 32'd1;
          out_data.hit_total    <= st_hit + 32'(hit);
          out_data.miss_total   <= st_miss + 32'(!hit);
          out_data.evict_total  <= st_evict + 32'(full_pick);
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/set_assoc_cache_tag_model_core.sv
// Top level of the set-associative cache tag store with selectable replacement.
// In the lookup engine the idle state reads the set row of a transaction from the
// set memories; the lookup state then resolves hit or victim and writes it back.
// A new access is read only once the last is written back and its result taken.
// After reset a clearing pass over all MAX_SETS sets zeroes the valid bits,
// stamp counters and round-robin pointers; no input is accepted meanwhile.
module set_assoc_cache_tag_model_core import sacm_pkg::*; #(
  parameter int MAX_SETS = DEF_MAX_SETS,
  parameter int MAX_WAYS = DEF_MAX_WAYS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data
);

  cfg_t     cfg;
  q_entry_t f_entry, q_head;
  logic     q_full, q_not_empty, q_pop, clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.replace_policy    <= POL_LRU;
      cfg.write_miss_policy <= 1'b0;
      cfg.block_size_log2   <= 4'd5;
      cfg.set_count_log2    <= 3'd6;
      cfg.way_count_log2    <= 2'd3;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_REPLACE_POLICY:    cfg.replace_policy    <= cfg_data[1:0];
        REG_WRITE_MISS_POLICY: cfg.write_miss_policy <= cfg_data[0];
        REG_BLOCK_SIZE_LOG2:   cfg.block_size_log2   <= cfg_data[3:0];
        REG_SET_COUNT_LOG2:    cfg.set_count_log2    <= cfg_data[2:0];
        REG_WAY_COUNT_LOG2:    cfg.way_count_log2    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full && !clearing && !rst;

  sacm_front #(.MAX_SETS(MAX_SETS)) u_front (
    .cfg   (cfg),
    .item  (in_data),
    .entry (f_entry)
  );

  sacm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_data (f_entry),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  sacm_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

>>> rtl/core/sacm_checker.sv
// Port-level checks for the cache tag store, bound to the top level.
// Depends on sacm_pkg.
module sacm_checker import sacm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_evict_alloc: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.hit && out_data.allocated) &&
                  (!out_data.evicted || out_data.allocated))
    else $error("inconsistent hit, allocate and evict flags");

  a_totals: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.access_total == out_data.hit_total + out_data.miss_total)
    else $error("access total differs from hits plus misses");

endmodule

bind set_assoc_cache_tag_model_core sacm_checker u_sacm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> sim/tb_set_assoc_cache_tag_model_core.sv
// Self-checking testbench for the set-associative cache tag store core.
// Depends on sacm_pkg and set_assoc_cache_tag_model_core; predicts every access
// result in-bench and compares it with the block's output transaction.
`timescale 1ns / 100ps

module tb_set_assoc_cache_tag_model_core;
  import sacm_pkg::*;

  localparam int NSETS = 64;
  localparam int NWAYS = 8;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  set_assoc_cache_tag_model_core dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predicted cache state and configuration.
  logic [1:0] pol;
  logic       no_wr_alloc;
  logic [3:0] blk_lg;
  logic [2:0] set_lg;
  logic [1:0] way_lg;
  logic        vld [NSETS*NWAYS];
  logic [31:0] tags [NSETS*NWAYS];
  logic [31:0] stamps [NSETS*NWAYS];
  logic [31:0] set_clock [NSETS];
  logic [2:0]  rr_ptr [NSETS];
  logic [15:0] lfsr;
  logic [31:0] n_acc, n_hit, n_miss, n_evict;

  in_t  access_q [$];
  out_t result_q [$];
  int   n_bad = 0;
  int   idle_cycles = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic out_t predict_access(in_t a);
    out_t o;
    int sb, nw, set_i, base, way, oldest;
    logic [31:0] tg;
    logic [15:0] v;
    logic fb;
    o = '0;
    sb = set_lg;
    while (sb > 0 && (1 << sb) > NSETS) sb--;
    nw = 1 << way_lg;
    set_i = (a.address >> blk_lg) & ((1 << sb) - 1);
    tg = a.address >> (blk_lg + sb);
    base = set_i * NWAYS;
    way = 0;
    for (int w = 0; w < nw; w++) begin
      if (!o.hit && vld[base+w] && tags[base+w] == tg) begin
        o.hit = 1'b1;
        way = w;
      end
    end
    if (o.hit) begin
      stamps[base+way] = set_clock[set_i];
      set_clock[set_i]++;
    end else if (!(a.mode && no_wr_alloc)) begin
      way = -1;
      oldest = 0;
      for (int w = 0; w < nw; w++) begin
        if (way < 0) begin
          if (!vld[base+w]) way = w;
          else if (stamps[base+w] < stamps[base+oldest]) oldest = w;
        end
      end
      if (way < 0) begin
        case (pol)
          POL_RANDOM: begin
            v = lfsr;
            fb = v[0] ^ v[2] ^ v[3] ^ v[5];
            lfsr = {fb, v[15:1]};
            way = lfsr & (nw - 1);
          end
          POL_RROBIN: begin
            way = rr_ptr[set_i] & (nw - 1);
            rr_ptr[set_i]++;
          end
          POL_LRU: way = oldest;
          default: way = 0;
        endcase
      end
      o.evicted = vld[base+way];
      o.allocated = 1'b1;
      vld[base+way] = 1'b1;
      tags[base+way] = tg;
      stamps[base+way] = set_clock[set_i];
      set_clock[set_i]++;
    end
    n_acc++;
    if (o.hit) n_hit++;
    else n_miss++;
    if (o.evicted) n_evict++;
    o.way_used = o.hit || o.allocated ? 3'(way) : 3'd0;
    o.access_total = n_acc;
    o.hit_total = n_hit;
    o.miss_total = n_miss;
    o.evict_total = n_evict;
    return o;
  endfunction

  // Handshakes are captured at the rising edge and consumed at the falling edge.
  bit in_acc, out_acc;
  out_t seen;
  always @(posedge clk) begin
    in_acc <= !rst && in_valid && in_ready;
    out_acc <= !rst && out_valid && out_ready;
    seen <= out_data;
  end

  // Driver: presents queued accesses with random gaps between them.
  int drv_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_acc) begin
        result_q.push_back(predict_access(in_data));
        void'(access_q.pop_front());
        drv_gap = gap_len();
      end
      if (in_valid && !in_acc) begin
        // hold the transaction until accepted
      end else if (drv_gap > 0) begin
        drv_gap--;
        in_valid <= 1'b0;
      end else if (access_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= access_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each result transaction with the oldest prediction and applies random back-pressure on out_ready.
  int rcv_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (out_acc) begin
        if (result_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result transaction %p", seen);
        end else begin
          if (seen !== result_q[0]) begin
            n_bad++;
            if (n_bad <= 10) $display("expected %p, got %p", result_q[0], seen);
          end
          void'(result_q.pop_front());
        end
      end
      if (rcv_gap > 0) begin
        rcv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_acc) rcv_gap = gap_len();
      end
      idle_cycles = (in_acc || out_acc) ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("set_assoc_cache_tag_model_core: mismatch");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_index_t idx, int val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    case (idx)
      REG_REPLACE_POLICY:    pol = 2'(val);
      REG_WRITE_MISS_POLICY: no_wr_alloc = 1'(val);
      REG_BLOCK_SIZE_LOG2:   blk_lg = 4'(val);
      REG_SET_COUNT_LOG2:    set_lg = 3'(val);
      REG_WAY_COUNT_LOG2:    way_lg = 2'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_drained();
    while (access_q.size() > 0 || result_q.size() > 0 || in_valid) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_config(int p, int wm, int b, int s, int w);
    wait_drained();
    write_reg(REG_REPLACE_POLICY, p);
    write_reg(REG_WRITE_MISS_POLICY, wm);
    write_reg(REG_BLOCK_SIZE_LOG2, b);
    write_reg(REG_SET_COUNT_LOG2, s);
    write_reg(REG_WAY_COUNT_LOG2, w);
  endtask

  // Addresses drawn mostly from a small pool of tags per set so hits and
  // evictions both happen often.
  function automatic in_t rand_access();
    in_t a;
    a.mode = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 8)
      a.address = ($urandom_range(0, 11) << 13) ^ ($urandom_range(0, 15) << 5)
                  ^ ($urandom_range(0, 3) << 28) ^ $urandom_range(0, 31);
    else
      a.address = $urandom;
    return a;
  endfunction

  initial begin
    in_t a;
    pol = POL_LRU;
    no_wr_alloc = 1'b0;
    blk_lg = 4'd5;
    set_lg = 3'd6;
    way_lg = 2'd3;
    for (int i = 0; i < NSETS*NWAYS; i++) begin
      vld[i] = 1'b0;
      tags[i] = '0;
      stamps[i] = '0;
    end
    for (int i = 0; i < NSETS; i++) begin
      set_clock[i] = '0;
      rr_ptr[i] = '0;
    end
    lfsr = 16'hACE1;
    n_acc = '0; n_hit = '0; n_miss = '0; n_evict = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extreme addresses, fills of one set past its ways, and rereads.
    a.mode = 1'b0; a.address = 32'h0; access_q.push_back(a);
    a.mode = 1'b1; a.address = 32'hFFFF_FFFF; access_q.push_back(a);
    a.mode = 1'b0; a.address = 32'h0; access_q.push_back(a);
    for (int i = 0; i < 10; i++) begin
      a.mode = i[0];
      a.address = (i + 1) << 11;
      access_q.push_back(a);
    end
    a.mode = 1'b0; a.address = 32'h0000_0800; access_q.push_back(a);
    a.mode = 1'b1; a.address = 32'hFFFF_FFE0; access_q.push_back(a);

    // Write miss without allocation, large block, oversized set count, random victims.
    set_config(POL_RANDOM, 1, 15, 7, 3);
    for (int i = 0; i < 10; i++) begin
      a.mode = 1'($urandom_range(0, 1));
      a.address = $urandom;
      access_q.push_back(a);
    end

    // Random phases sweeping every setting, extremes included.
    for (int ph = 0; ph < 16; ph++) begin
      case (ph)
        0: set_config(POL_RANDOM, 0, 0, 0, 0);
        1: set_config(POL_RROBIN, 0, 12, 6, 3);
        2: set_config(POL_LRU, 1, 5, 3, 2);
        3: set_config(3, 0, 4, 2, 3);
        4: set_config(POL_RROBIN, 1, 15, 7, 1);
        default: set_config($urandom_range(0, 3), $urandom_range(0, 1),
                            $urandom_range(0, 15), $urandom_range(0, 7),
                            $urandom_range(0, 3));
      endcase
      for (int i = 0; i < 120; i++) access_q.push_back(rand_access());
    end
    wait_drained();
    repeat (20) @(negedge clk);
    if (n_bad == 0 && result_q.size() == 0)
      $display("set_assoc_cache_tag_model_core: match");
    else
      $display("set_assoc_cache_tag_model_core: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/sacm_pkg.sv
rtl/core/sacm_front.sv
rtl/core/sacm_queue.sv
rtl/core/sacm_back.sv
rtl/core/set_assoc_cache_tag_model_core.sv
rtl/core/sacm_checker.sv
sim/tb_set_assoc_cache_tag_model_core.sv
